// ----- rtl/core/forth_data_stack_alu_core_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the data stack core
// Shared concurrent check wrappers.
// ----------------------------------------------------------------------------
`ifndef FORTH_DATA_STACK_ALU_CORE_DEFINES_SVH
`define FORTH_DATA_STACK_ALU_CORE_DEFINES_SVH
// implication checked every clock, quiet in reset
`define FDS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("check failed");
// next-cycle implication
`define FDS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("check failed");
`endif

// ----- rtl/core/fdsa_pkg.sv -----
// ----------------------------------------------------------------------------
// fdsa_pkg
// Types, opcodes and constants for the data stack core.
// ----------------------------------------------------------------------------
package fdsa_pkg;
    localparam int STACK_DEPTH = 64;
    localparam int WORD_WIDTH  = 32;
    localparam int DW          = $clog2(STACK_DEPTH + 1);
    localparam int AW          = $clog2(STACK_DEPTH);
    localparam int DIV_CW      = $clog2(WORD_WIDTH + 1);

    typedef logic [WORD_WIDTH-1:0] t_word;
    typedef logic [DW-1:0]         t_depth;

    typedef enum logic [4:0] {
        OP_PUSH = 5'd0, OP_POP = 5'd1, OP_PEEK = 5'd2, OP_DUP = 5'd3,
        OP_SWAP = 5'd4, OP_OVER = 5'd5, OP_ROT = 5'd6, OP_2DUP = 5'd7,
        OP_2SWAP = 5'd8, OP_2OVER = 5'd9, OP_ADD = 5'd10, OP_SUB = 5'd11,
        OP_MUL = 5'd12, OP_DIV = 5'd13, OP_MOD = 5'd14, OP_DIVMOD = 5'd15,
        OP_AND = 5'd16, OP_OR = 5'd17, OP_LESS = 5'd18, OP_GREATER = 5'd19,
        OP_EQUAL = 5'd20, OP_INVERT = 5'd21
    } t_op;

    typedef enum logic [1:0] {
        ST_OK = 2'd0, ST_UNDER = 2'd1, ST_OVER = 2'd2, ST_DIVZ = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE, S_DIV, S_DONE
    } t_state;

    // cell control: shift whole row by k (push side) or keep, plus top writes
    typedef struct packed {
        logic          load;   // take new top six from the write bus
        logic [2:0]    pop_n;  // entries removed
        logic [2:0]    push_n; // entries added after removal
        t_word [5:0]   wr;     // values r[0..5], r[0] deepest
    } t_cell_ctl;

    function automatic logic [2:0] op_need(input logic [4:0] m);
        case (m) inside
            OP_PUSH: return 3'd0;
            OP_POP, OP_PEEK, OP_DUP, OP_INVERT: return 3'd1;
            OP_ROT: return 3'd3;
            OP_2SWAP, OP_2OVER: return 3'd4;
            default: return 3'd2;
        endcase
    endfunction

    function automatic logic [2:0] op_make(input logic [4:0] m);
        case (m) inside
            OP_POP: return 3'd0;
            OP_PEEK, OP_PUSH: return 3'd1;
            OP_DUP, OP_SWAP, OP_DIVMOD: return 3'd2;
            OP_OVER, OP_ROT: return 3'd3;
            OP_2DUP, OP_2SWAP: return 3'd4;
            OP_2OVER: return 3'd6;
            default: return 3'd1;
        endcase
    endfunction
endpackage

// ----- rtl/core/fdsa_cell.sv -----
// ----------------------------------------------------------------------------
// fdsa_cell
// One stack slot; index 0 is the top. Takes a neighbour's word when the
// row shifts, or a freshly computed word when it lands in the top six.
// ----------------------------------------------------------------------------
module fdsa_cell (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [2:0]        i_sel,   // 0 hold, 1 from bus, 2 from shift
    input  fdsa_pkg::t_word   i_bus,
    input  fdsa_pkg::t_word   i_shift,
    output fdsa_pkg::t_word   o_word
);
    import fdsa_pkg::*;
    t_word r_word;
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            case (i_sel)
                3'd1:    r_word <= i_bus;
                3'd2:    r_word <= i_shift;
                default: r_word <= r_word;
            endcase
        end
    end
    assign o_word = r_word;
endmodule

// ----- rtl/core/fdsa_divider.sv -----
// ----------------------------------------------------------------------------
// fdsa_divider
// Signed restoring divider, one quotient bit per cycle, truncating.
// ----------------------------------------------------------------------------
module fdsa_divider (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  fdsa_pkg::t_word i_a,
    input  fdsa_pkg::t_word i_b,
    output logic            o_done,
    output fdsa_pkg::t_word o_quot,
    output fdsa_pkg::t_word o_rem
);
    import fdsa_pkg::*;
    logic [DIV_CW-1:0] r_cnt;
    logic              r_busy, r_qneg, r_rneg;
    t_word             r_q, r_d;
    logic [WORD_WIDTH:0] r_r;
    logic [WORD_WIDTH:0] w_trial;

    assign w_trial = {r_r[WORD_WIDTH-1:0], r_q[WORD_WIDTH-1]} - {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CW'(WORD_WIDTH);
                r_q    <= i_a[WORD_WIDTH-1] ? t_word'(-i_a) : i_a;
                r_d    <= i_b[WORD_WIDTH-1] ? t_word'(-i_b) : i_b;
                r_r    <= '0;
                r_qneg <= i_a[WORD_WIDTH-1] ^ i_b[WORD_WIDTH-1];
                r_rneg <= i_a[WORD_WIDTH-1];
            end else if (r_busy) begin
                if (!w_trial[WORD_WIDTH]) begin
                    r_r <= w_trial;
                    r_q <= {r_q[WORD_WIDTH-2:0], 1'b1};
                end else begin
                    r_r <= {r_r[WORD_WIDTH-1:0], r_q[WORD_WIDTH-1]};
                    r_q <= {r_q[WORD_WIDTH-2:0], 1'b0};
                end
                r_cnt <= r_cnt - DIV_CW'(1);
                if (r_cnt == DIV_CW'(1)) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end
    assign o_quot = r_qneg ? t_word'(-r_q) : r_q;
    assign o_rem  = r_rneg ? t_word'(-r_r[WORD_WIDTH-1:0]) : r_r[WORD_WIDTH-1:0];
endmodule

// ----- rtl/core/forth_data_stack_alu_core.sv -----
// ----------------------------------------------------------------------------
// forth_data_stack_alu_core
// Bounded Forth data stack with ALU, built as a row of shifting cells.
// ----------------------------------------------------------------------------
// Issue a command with start while busy is low. The result appears on
// o_status / o_result_value / o_stack_depth for one cycle with o_done, and
// cannot be held off: sample it then. Stack ops pass through S_DIV and
// S_DONE from accept to result; div, mod and divmod also wait in S_DIV for
// the one-bit-a-cycle divider (a divide that underflows or has a zero divisor
// does not start it). busy is high from accept until the result cycle, so the
// next command can be accepted at the end of the result cycle, not earlier.
// Capacity is written through the cfg channel; o_cfg_ready is low while busy.
module forth_data_stack_alu_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [4:0]  i_mode,
    input  logic signed [31:0] i_push_value,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [6:0]  i_cfg_data,
    output logic        o_done,
    output logic [1:0]  o_status,
    output logic signed [31:0] o_result_value,
    output logic [6:0]  o_stack_depth
);
    import fdsa_pkg::*;
    `include "forth_data_stack_alu_core_defines.svh"

    t_state  r_state, n_state;
    t_depth  r_depth;
    logic [6:0] r_cap;
    logic [4:0] r_mode;
    t_word   r_pv;
    t_word   w_cell [STACK_DEPTH];
    t_cell_ctl w_ctl;
    logic    w_apply, w_div_done;
    t_word   w_q, w_m;
    t_status w_st;
    t_word   w_res;
    t_depth  w_new_depth;
    logic    div_go;
    logic    r_div_wait;

    // capacity only changes between transactions
    assign o_cfg_ready = !busy;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_cap <= 7'd64;
        else if (i_cfg_valid && o_cfg_ready) r_cap <= i_cfg_data;
    end

    // operands: s0 deepest of need; cell k is depth-1-k from bottom, top = 0
    logic [2:0] w_need, w_make;
    t_word s0, s1, s2, s3;
    t_depth w_cap;
    assign w_need = op_need(r_mode);
    assign w_make = op_make(r_mode);
    assign w_cap  = (r_cap > 7'(STACK_DEPTH)) ? t_depth'(STACK_DEPTH) : t_depth'(r_cap);
    always_comb begin
        s0 = w_cell[AW'(w_need) - AW'(1)];
        s1 = (w_need >= 3'd2) ? w_cell[AW'(w_need) - AW'(2)] : '0;
        s2 = (w_need == 3'd3) ? w_cell[0] : w_cell[1];
        s3 = w_cell[0];
    end

    fdsa_divider u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_start(div_go),
        .i_a(s0), .i_b(s1), .o_done(w_div_done), .o_quot(w_q), .o_rem(w_m)
    );

    logic w_isdiv, w_under, w_divz, w_ovf, w_unk;
    assign w_unk   = r_mode > OP_INVERT;
    assign w_isdiv = r_mode == OP_DIV || r_mode == OP_MOD || r_mode == OP_DIVMOD;
    assign w_under = !w_unk && (r_depth < t_depth'(w_need));
    assign w_divz  = w_isdiv && s1 == '0;
    assign w_ovf   = (w_make > w_need) &&
                     (({1'b0, r_depth} + (DW+1)'(w_make) - (DW+1)'(w_need)) >
                      {1'b0, w_cap});

    // S_DIV holds the command and runs the divider when needed;
    // S_DONE evaluates and commits
    always_comb begin
        unique case (r_state)
            S_IDLE:  n_state = start ? S_DIV : S_IDLE;
            S_DIV:   n_state = (div_go || (r_div_wait && !w_div_done)) ? S_DIV : S_DONE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        busy   = 1'b1;
        div_go = 1'b0;
        unique case (r_state)
            S_IDLE:  busy = 1'b0;
            S_DIV:   div_go = !r_div_wait && !w_div_done && w_isdiv && !w_under && !w_divz;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_depth    <= '0;
            r_div_wait <= 1'b0;
        end else begin
            r_state <= n_state;
            if (div_go) r_div_wait <= 1'b1;
            else if (w_div_done) r_div_wait <= 1'b0;
            if (w_apply) r_depth <= w_new_depth;
        end
    end

    // command capture on accept
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && start) begin
            r_mode <= i_mode;
            r_pv   <= i_push_value;
        end
    end

    // evaluate
    always_comb begin
        w_ctl = '0;
        w_st  = ST_OK;
        w_ctl.pop_n  = w_need;
        w_ctl.push_n = w_make;
        case (r_mode)
            OP_PUSH:   w_ctl.wr[0] = r_pv;
            OP_PEEK:   w_ctl.wr[0] = s0;
            OP_DUP:    begin w_ctl.wr[0] = s0; w_ctl.wr[1] = s0; end
            OP_SWAP:   begin w_ctl.wr[0] = s1; w_ctl.wr[1] = s0; end
            OP_OVER:   begin w_ctl.wr[0] = s0; w_ctl.wr[1] = s1; w_ctl.wr[2] = s0; end
            OP_ROT:    begin w_ctl.wr[0] = s1; w_ctl.wr[1] = s2; w_ctl.wr[2] = s0; end
            OP_2DUP:   begin w_ctl.wr[0] = s0; w_ctl.wr[1] = s1;
                             w_ctl.wr[2] = s0; w_ctl.wr[3] = s1; end
            OP_2SWAP:  begin w_ctl.wr[0] = s2; w_ctl.wr[1] = s3;
                             w_ctl.wr[2] = s0; w_ctl.wr[3] = s1; end
            OP_2OVER:  begin w_ctl.wr[0] = s0; w_ctl.wr[1] = s1; w_ctl.wr[2] = s2;
                             w_ctl.wr[3] = s3; w_ctl.wr[4] = s0; w_ctl.wr[5] = s1; end
            OP_ADD:    w_ctl.wr[0] = s0 + s1;
            OP_SUB:    w_ctl.wr[0] = s0 - s1;
            OP_MUL:    w_ctl.wr[0] = t_word'(s0 * s1);
            OP_DIV:    w_ctl.wr[0] = w_q;
            OP_MOD:    w_ctl.wr[0] = w_m;
            OP_DIVMOD: begin w_ctl.wr[0] = w_m; w_ctl.wr[1] = w_q; end
            OP_AND:    w_ctl.wr[0] = t_word'(s0 != '0 && s1 != '0);
            OP_OR:     w_ctl.wr[0] = t_word'(s0 != '0 || s1 != '0);
            OP_LESS:   w_ctl.wr[0] = t_word'($signed(s0) < $signed(s1));
            OP_GREATER:w_ctl.wr[0] = t_word'($signed(s0) > $signed(s1));
            OP_EQUAL:  w_ctl.wr[0] = t_word'(s0 == s1);
            OP_INVERT: w_ctl.wr[0] = t_word'(s0 == '0);
            default:   w_ctl.wr[0] = '0;
        endcase
        if (w_unk)       w_st = ST_OK;
        else if (w_under) w_st = ST_UNDER;
        else if (w_divz)  w_st = ST_DIVZ;
        else if (w_ovf)   w_st = ST_OVER;
        w_ctl.load = (r_state == S_DONE) && !w_unk && (w_st == ST_OK);
    end
    assign w_apply = w_ctl.load;
    assign w_new_depth = t_depth'(r_depth - t_depth'(w_need) + t_depth'(w_make));

    // row of cells: net shift = make - need; top make cells from bus
    logic signed [3:0] w_shift;
    assign w_shift = $signed({1'b0, w_make}) - $signed({1'b0, w_need});
    generate
        for (genvar k = 0; k < STACK_DEPTH; k++) begin : g_row
            logic [2:0] w_sel;
            t_word      w_bus;
            t_word      w_src;
            always_comb begin
                w_sel = 3'd0;
                w_bus = w_ctl.wr[0];
                if (k < 6 && 3'(k) < w_make) begin
                    w_sel = 3'd1;
                    w_bus = w_ctl.wr[3'(w_make - 3'd1 - 3'(k))];
                end else if (w_shift != 0) begin
                    w_sel = 3'd2;
                end
            end
            always_comb begin
                w_src = '0;
                for (int d = -6; d <= 6; d++) begin
                    if (w_shift == 4'(d) && k - d >= 0 && k - d < STACK_DEPTH)
                        w_src = w_cell[AW'(k - d)];
                end
            end
            fdsa_cell u_cell (
                .i_clk(i_clk), .i_en(w_apply), .i_sel(w_sel),
                .i_bus(w_bus), .i_shift(w_src), .o_word(w_cell[k])
            );
        end
    endgenerate

    // result
    t_depth w_out_depth;
    always_comb begin
        w_out_depth = (w_st == ST_OK && !w_unk) ? w_new_depth : r_depth;
        if (r_mode == OP_POP && w_st == ST_OK) w_res = s0;
        else if (w_st == ST_OK && !w_unk) w_res = (w_make != 0) ? w_ctl.wr[3'(w_make - 3'd1)]
                                                : ((r_depth > t_depth'(w_need)) ?
                                                   w_cell[AW'(w_need)] : '0);
        else w_res = (r_depth != '0) ? w_cell[0] : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) o_done <= 1'b0;
        else o_done <= r_state == S_DONE;
        o_status       <= w_st;
        o_result_value <= w_res;
        o_stack_depth  <= 7'(w_out_depth);
    end

    `FDS_ASSERT_IMP(a_depth_cap, i_clk, i_rst_n, 1'b1, r_depth <= t_depth'(STACK_DEPTH))
    `FDS_ASSERT_NXT(a_done_after, i_clk, i_rst_n, r_state == S_DONE, o_done)
    `FDS_ASSERT_IMP(a_div_busy, i_clk, i_rst_n, r_div_wait, busy)
endmodule
